// ----- rtl/core/lr_pkg.sv -----
// Shared types and constants for the line rasterizer.
`default_nettype none
package lr_pkg;

    localparam int COORD_W  = 6;
    localparam int COLOUR_W = 8;
    localparam int STRIDE_W = 12;
    localparam int CANVAS_W = 7;
    localparam int OFFSET_W = 18;
    localparam int ERR_W    = 9;
    localparam int IDX_W    = 2;
    localparam int MAX_SIDE = 64;

    localparam logic [IDX_W-1:0] REG_ROW_STRIDE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd2;

    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST    = 12'd64;
    localparam logic [CANVAS_W-1:0] CANVAS_WIDTH_RST  = 7'd64;
    localparam logic [CANVAS_W-1:0] CANVAS_HEIGHT_RST = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } walk_state_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic [COORD_W-1:0]  end_y;
        logic [COORD_W-1:0]  end_x;
        logic [COORD_W-1:0]  start_y;
        logic [COORD_W-1:0]  start_x;
    } cmd_t;

    typedef struct packed {
        logic                valid;
        logic                last;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COLOUR_W-1:0] colour;
    } pixel_t;

    typedef struct packed {
        logic [STRIDE_W-1:0] row_stride;
        logic [CANVAS_W-1:0] canvas_width;
        logic [CANVAS_W-1:0] canvas_height;
    } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/lr_walker.sv -----
// Command register, line setup and Bresenham sequencer around one shared error adder.
`default_nettype none
module lr_walker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire lr_pkg::cmd_t   cmd,
    input  wire logic           out_ready,
    output lr_pkg::pixel_t      pix
);
    import lr_pkg::*;

    walk_state_t        state_reg, state_next;
    cmd_t               cmd_reg;
    logic [COORD_W-1:0] u_reg, u_next;
    logic [COORD_W-1:0] v_reg, v_next;
    logic [ERR_W-1:0]   d_reg, d_next;
    logic [ERR_W-1:0]   inc_diag_reg, inc_diag_next;
    logic [ERR_W-1:0]   inc_str_reg, inc_str_next;
    logic [COORD_W-1:0] rem_reg, rem_next;
    logic               steep_reg, steep_next;
    logic               step_neg_reg, step_neg_next;

    // Setup terms
    logic [COORD_W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2;
    logic [COORD_W-1:0] adx, ady, major, minor;
    logic               shallow;
    logic [ERR_W-1:0]   minor2, major9;

    // Shared error adder
    logic [ERR_W-1:0]   add_a, add_b, add_sum;
    logic               d_pos;
    logic               advance;

    always_comb
    begin
        if (cmd_reg.end_x < cmd_reg.start_x)
        begin
            ax1 = cmd_reg.end_x;   ay1 = cmd_reg.end_y;
            ax2 = cmd_reg.start_x; ay2 = cmd_reg.start_y;
        end
        else
        begin
            ax1 = cmd_reg.start_x; ay1 = cmd_reg.start_y;
            ax2 = cmd_reg.end_x;   ay2 = cmd_reg.end_y;
        end
        adx = ax2 - ax1;
        ady = (ay2 >= ay1) ? (ay2 - ay1) : (ay1 - ay2);
        shallow = (ady < adx);
        if (ay1 > ay2)
        begin
            bx1 = ax2; by1 = ay2; bx2 = ax1;
        end
        else
        begin
            bx1 = ax1; by1 = ay1; bx2 = ax2;
        end
        major  = shallow ? adx : ady;
        minor  = shallow ? ady : adx;
        minor2 = {2'b00, minor, 1'b0};
        major9 = {3'b000, major};
    end

    assign d_pos = !d_reg[ERR_W-1] && (d_reg != '0);

    // During setup the adder forms 2*minor - major; during the walk it steps the error.
    always_comb
    begin
        if (state_reg == ST_SETUP)
        begin
            add_a = minor2;
            add_b = ~major9 + 9'd1;
        end
        else
        begin
            add_a = d_reg;
            add_b = d_pos ? inc_diag_reg : inc_str_reg;
        end
        add_sum = add_a + add_b;
    end

    assign advance = (state_reg == ST_WALK) && out_ready;

    always_comb
    begin
        state_next    = state_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        d_next        = d_reg;
        inc_diag_next = inc_diag_reg;
        inc_str_next  = inc_str_reg;
        rem_next      = rem_reg;
        steep_next    = steep_reg;
        step_neg_next = step_neg_reg;
        cmd_ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                steep_next    = !shallow;
                step_neg_next = shallow ? (ay2 < ay1) : (bx2 < bx1);
                u_next        = shallow ? ax1 : by1;
                v_next        = shallow ? ay1 : bx1;
                d_next        = add_sum;
                inc_str_next  = minor2;
                inc_diag_next = minor2 - {2'b00, major, 1'b0};
                if ({1'b0, major} > 7'(MAX_SIDE - 1))
                begin
                    rem_next = COORD_W'(MAX_SIDE - 1);
                end
                else
                begin
                    rem_next = major;
                end
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (advance)
                begin
                    u_next   = u_reg + 6'd1;
                    d_next   = add_sum;
                    rem_next = rem_reg - 6'd1;
                    if (d_pos)
                    begin
                        v_next = step_neg_reg ? (v_reg - 6'd1) : (v_reg + 6'd1);
                    end
                    if (rem_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pix.valid  = (state_reg == ST_WALK);
        pix.last   = (rem_reg == '0);
        pix.x      = steep_reg ? v_reg : u_reg;
        pix.y      = steep_reg ? u_reg : v_reg;
        pix.colour = cmd_reg.colour;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        u_reg        <= u_next;
        v_reg        <= v_next;
        d_reg        <= d_next;
        inc_diag_reg <= inc_diag_next;
        inc_str_reg  <= inc_str_next;
        rem_reg      <= rem_next;
        steep_reg    <= steep_next;
        step_neg_reg <= step_neg_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/lr_pixel_out.sv -----
// Offset multiply-add, canvas clip and output register for the pixel stream.
`default_nettype none
module lr_pixel_out (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lr_pkg::pixel_t pix,
    input  wire lr_pkg::cfg_t   cfg,
    output logic                out_ready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [31:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);
    import lr_pkg::*;

    logic                out_valid_reg;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [COLOUR_W-1:0] colour_reg;
    logic                we_reg, we_next;
    logic                last_reg;
    logic                load;

    assign out_ready = !out_valid_reg || m_tready;
    assign load      = pix.valid && out_ready;

    always_comb
    begin
        offset_next = (OFFSET_W'(cfg.row_stride) * OFFSET_W'(pix.y)) + OFFSET_W'(pix.x);
        we_next     = ({1'b0, pix.x} < cfg.canvas_width) && ({1'b0, pix.y} < cfg.canvas_height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            offset_reg <= offset_next;
            colour_reg <= pix.colour;
            we_reg     <= we_next;
            last_reg   <= pix.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, colour_reg, offset_reg};
    assign m_tuser  = we_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

// ----- rtl/core/line_rasterizer_core.sv -----
// Line rasterizer top level: stream ports, configuration registers and the two stages.
//
// A line command arrives as one beat on the s_ channel: two endpoints and a colour.
// The block then walks the line with the Bresenham error term and sends one beat per
// pixel on the m_ channel: frame-buffer offset x + row_stride*y, the colour, a write
// enable in m_tuser (low when the pixel lies outside the canvas) and m_tlast on the
// final pixel of the line.
// A command is captured in the idle state, set up in the setup state and then walked
// pixel by pixel, max(|dx|,|dy|)+1 pixels, so up to 64 pixels; the pixel rate is set by the
// single error adder, which is stepped once per pixel. The first pixel reaches m_
// after the setup state and the output register. s_tready stays low from the command beat
// until the last pixel has been handed to the output register.
// When the receiver stalls, the output register holds its beat and the walk pauses.
// The cfg_ channel writes row_stride (index 0), canvas_width (1) and canvas_height (2);
// it is always ready and should only be used while no line is in flight.
// Reset sets the stride, width and height to 64 and leaves the block idle and ready.
`default_nettype none
module line_rasterizer_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [31:0]            s_tdata,  // start_x, start_y, end_x, end_y, colour
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [31:0]                 m_tdata,  // pixel_offset[17:0], pixel_colour, 0 pad
    output logic                        m_tuser,  // write_enable
    output logic                        m_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [lr_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [lr_pkg::STRIDE_W-1:0] cfg_data
);
    import lr_pkg::*;

    cfg_t   cfg_reg;
    cmd_t   cmd;
    pixel_t pix;
    logic   out_ready;

    assign cfg_ready = 1'b1;
    assign cmd       = cmd_t'(s_tdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_stride    <= ROW_STRIDE_RST;
            cfg_reg.canvas_width  <= CANVAS_WIDTH_RST;
            cfg_reg.canvas_height <= CANVAS_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_STRIDE:    cfg_reg.row_stride    <= cfg_data;
                REG_CANVAS_WIDTH:  cfg_reg.canvas_width  <= cfg_data[CANVAS_W-1:0];
                REG_CANVAS_HEIGHT: cfg_reg.canvas_height <= cfg_data[CANVAS_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    lr_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .out_ready (out_ready),
        .pix       (pix)
    );

    lr_pixel_out u_pixel_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .cfg       (cfg_reg),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// ----- rtl/core/lr_checker.sv -----
// Port-level checks for the line rasterizer, bound to the top level.
`default_nettype none
module lr_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic [31:0]                  s_tdata,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [31:0]                  m_tdata,
    input wire logic                         m_tuser,
    input wire logic                         m_tlast,
    input wire logic                         cfg_valid,
    input wire logic                         cfg_ready,
    input wire logic [lr_pkg::IDX_W-1:0]     cfg_index,
    input wire logic [lr_pkg::STRIDE_W-1:0]  cfg_data
);

    // A command beat closes the input until its line has been walked.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready straight after a command beat");

    // While idle, only the final pixel of the previous line may still be waiting.
    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && m_tvalid) |-> m_tlast)
        else $error("idle with a non-final pixel pending");

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

    // No pixel can come out before a command has been taken and set up.
    a_no_early_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("pixel appeared in the cycle after a command beat");

    wire unused_ok = cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data) ^ (^s_tdata);

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (.*);
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for line_rasterizer_core: stimulus, pixel prediction and scoreboard.
`timescale 1ns / 100ps

module tb;
    import lr_pkg::*;

    localparam int LIMIT       = 600000;
    localparam int TAIL        = 80;
    localparam int CHUNKS      = 10;
    localparam int CHUNK_LINES = 21;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int OFFSET_MASK = (1 << OFFSET_W) - 1;
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic [OFFSET_W-1:0] offset;
        logic [COLOUR_W-1:0] colour;
        logic                we;
        logic                last;
    } pixel_beat_t;

    class pixel_scoreboard;
        logic [STRIDE_W-1:0] stride;
        logic [CANVAS_W-1:0] width;
        logic [CANVAS_W-1:0] height;
        pixel_beat_t         pending[$];
        int                  errors;

        function new();
            stride = ROW_STRIDE_RST;
            width  = CANVAS_WIDTH_RST;
            height = CANVAS_HEIGHT_RST;
            errors = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [STRIDE_W-1:0] data);
            case (idx)
                REG_ROW_STRIDE:    stride = data;
                REG_CANVAS_WIDTH:  width  = data[CANVAS_W-1:0];
                REG_CANVAS_HEIGHT: height = data[CANVAS_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending_count();
            return pending.size();
        endfunction

        // Walks the line with the Bresenham error term and queues every pixel it produces.
        function void add_line(cmd_t cmd);
            int x1, y1, x2, y2, t, adx, ady, major, minor, dir, u, v, d, n, i, px, py;
            bit shallow;
            pixel_beat_t beat;
            x1 = cmd.start_x;
            y1 = cmd.start_y;
            x2 = cmd.end_x;
            y2 = cmd.end_y;
            if (x2 < x1)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            adx = x2 - x1;
            ady = (y2 >= y1) ? y2 - y1 : y1 - y2;
            shallow = (ady < adx);
            if (shallow)
            begin
                major = adx;
                minor = ady;
                dir = (y2 < y1) ? -1 : 1;
                u = x1;
                v = y1;
            end
            else
            begin
                if (y1 > y2)
                begin
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                end
                major = ady;
                minor = adx;
                dir = (x2 < x1) ? -1 : 1;
                u = y1;
                v = x1;
            end
            n = major + 1;
            if (n > MAX_SIDE)
                n = MAX_SIDE;
            d = 2 * minor - major;
            for (i = 0; i < n; i++)
            begin
                px = (shallow ? u : v) & COORD_MAX;
                py = (shallow ? v : u) & COORD_MAX;
                beat.offset = OFFSET_W'((px + int'(stride) * py) & OFFSET_MASK);
                beat.colour = cmd.colour;
                beat.we     = (px < int'(width)) && (py < int'(height));
                beat.last   = (i == n - 1);
                pending.push_back(beat);
                if (d > 0)
                begin
                    v += dir;
                    d += 2 * (minor - major);
                end
                else
                    d += 2 * minor;
                u += 1;
            end
        endfunction

        function void check_pixel(logic [OFFSET_W-1:0] offset, logic [COLOUR_W-1:0] colour,
                                  logic we, logic last);
            pixel_beat_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel: offset %0d colour %0d we %0b last %0b",
                             offset, colour, we, last);
                return;
            end
            want = pending.pop_front();
            if (want.offset !== offset || want.colour !== colour ||
                want.we !== we || want.last !== last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"pixel mismatch: expected offset %0d colour %0d we %0b last %0b,",
                              " got offset %0d colour %0d we %0b last %0b"},
                             want.offset, want.colour, want.we, want.last,
                             offset, colour, we, last);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [STRIDE_W-1:0] cfg_data;

    int tx_idle;
    int rx_idle;
    int cycles;

    pixel_scoreboard sb = new();

    line_rasterizer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_pixel(m_tdata[OFFSET_W-1:0], m_tdata[OFFSET_W+COLOUR_W-1:OFFSET_W],
                           m_tuser, m_tlast);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [STRIDE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The valid line stays high from one accepted beat into the next unless a gap is taken.
    task automatic send_line(int x1, int y1, int x2, int y2, int col);
        cmd_t cmd;
        cmd.start_x = x1[COORD_W-1:0];
        cmd.start_y = y1[COORD_W-1:0];
        cmd.end_x   = x2[COORD_W-1:0];
        cmd.end_y   = y2[COORD_W-1:0];
        cmd.colour  = col[COLOUR_W-1:0];
        while ($urandom_range(99) < tx_idle)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        sb.add_line(cmd);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_count() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int chunk, k, x1, y1, x2, y2;
        logic [STRIDE_W-1:0] stride_val, width_val, height_val;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROW_STRIDE;
        cfg_data  = '0;
        cycles    = 0;
        tx_idle   = 8;
        rx_idle   = 55;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lines at the reset geometry: points, axes, diagonals and both slope signs.
        send_line(0, 0, 0, 0, 0);
        send_line(63, 63, 63, 63, 255);
        send_line(0, 0, 63, 0, 8'hA5);
        send_line(63, 63, 0, 63, 8'h5A);
        send_line(0, 0, 0, 63, 1);
        send_line(63, 63, 63, 0, 128);
        send_line(0, 0, 63, 63, 254);
        send_line(63, 0, 0, 63, 127);
        send_line(63, 63, 0, 0, 2);
        send_line(0, 40, 63, 10, 3);
        send_line(5, 3, 60, 20, 4);
        send_line(50, 0, 10, 63, 5);
        send_line(3, 2, 20, 61, 6);
        send_line(20, 61, 3, 2, 7);
        send_line(0, 0, 63, 62, 8);
        send_line(0, 0, 62, 63, 9);
        send_line(10, 10, 11, 10, 10);
        send_line(10, 10, 10, 11, 11);
        send_line(10, 10, 11, 11, 12);
        wait_drained();

        // Lines crossing the canvas edges, so part of each one is clipped.
        write_reg(REG_ROW_STRIDE, 12'd100);
        write_reg(REG_CANVAS_WIDTH, 12'd32);
        write_reg(REG_CANVAS_HEIGHT, 12'd16);
        write_reg(REG_UNMAPPED, 12'hFFF);
        send_line(0, 0, 63, 63, 8'hC3);
        send_line(40, 5, 10, 30, 8'h3C);
        send_line(20, 50, 20, 10, 8'h99);
        wait_drained();

        for (chunk = 0; chunk < CHUNKS; chunk++)
        begin
            if (chunk < 4)
            begin
                tx_idle = 8;
                rx_idle = 55;
            end
            else if (chunk < 7)
            begin
                tx_idle = 55;
                rx_idle = 8;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case (chunk)
                0: begin stride_val = 12'd4095; width_val = 12'd0;   height_val = 12'd0;   end
                1: begin stride_val = 12'd0;    width_val = 12'd127; height_val = 12'd127; end
                2: begin stride_val = 12'd1;    width_val = 12'd64;  height_val = 12'd1;   end
                3: begin stride_val = 12'd64;   width_val = 12'd1;   height_val = 12'd64;  end
                default:
                begin
                    stride_val = STRIDE_W'($urandom_range(4095));
                    width_val  = STRIDE_W'($urandom_range(4095));
                    height_val = STRIDE_W'($urandom_range(4095));
                end
            endcase
            write_reg(REG_ROW_STRIDE, stride_val);
            write_reg(REG_CANVAS_WIDTH, width_val);
            write_reg(REG_CANVAS_HEIGHT, height_val);

            for (k = 0; k < CHUNK_LINES; k++)
            begin
                x1 = $urandom_range(COORD_MAX);
                y1 = $urandom_range(COORD_MAX);
                // Most lines are short to keep the run brisk; the rest have endpoints anywhere on the grid.
                if ($urandom_range(9) < 6)
                begin
                    x2 = x1 + int'($urandom_range(16)) - 8;
                    y2 = y1 + int'($urandom_range(16)) - 8;
                    if (x2 < 0) x2 = 0;
                    if (x2 > COORD_MAX) x2 = COORD_MAX;
                    if (y2 < 0) y2 = 0;
                    if (y2 > COORD_MAX) y2 = COORD_MAX;
                end
                else
                begin
                    x2 = $urandom_range(COORD_MAX);
                    y2 = $urandom_range(COORD_MAX);
                end
                send_line(x1, y1, x2, y2, $urandom_range(255));
            end
            wait_drained();
        end

        repeat (TAIL) @(posedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
